[hdl/assert_macros.svh]
// assertion macros shared by the parser rtl
// no dependencies; clocked properties, disabled while the active-low reset is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FPP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define FPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/fpp_pkg.sv]
// shared types and constants for the framed packet parser
// no dependencies
package fpp_pkg;

    localparam int ERROR_COUNT_WIDTH_DEF = 16;
    localparam int CFG_INDEX_WIDTH       = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SYNC_BYTE      = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OVERHEAD_BYTES = 8'd1;

    localparam logic [7:0] SYNC_BYTE_RESET      = 8'd153;
    localparam logic [7:0] OVERHEAD_BYTES_RESET = 8'd6;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_BYTE  = 2'd1;
    localparam logic [1:0] EV_GOOD  = 2'd2;
    localparam logic [1:0] EV_ERROR = 2'd3;

    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_LEN     = 7'b0000010,
        PH_ACID    = 7'b0000100,
        PH_MSGID   = 7'b0001000,
        PH_PAYLOAD = 7'b0010000,
        PH_CK1     = 7'b0100000,
        PH_CK2     = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0] sync_byte;
        logic [7:0] overhead_bytes;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  payload_length;
        logic [7:0]  aircraft_id;
        logic [7:0]  message_id;
        logic [15:0] error_count;
    } t_result;

endpackage

[hdl/fpp_cfg.sv]
// configuration registers: sync byte and overhead byte count
// depends on fpp_pkg
module fpp_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [fpp_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [7:0]                         i_cfg_data,
    output logic                               o_cfg_ready,
    output fpp_pkg::t_cfg                      o_cfg
);

    logic [7:0] r_sync_byte;
    logic [7:0] r_overhead_bytes;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte      <= fpp_pkg::SYNC_BYTE_RESET;
            r_overhead_bytes <= fpp_pkg::OVERHEAD_BYTES_RESET;
        end else if (i_cfg_valid) begin
            // writes beyond the two registers are dropped
            unique case (i_cfg_index)
                fpp_pkg::CFG_SYNC_BYTE:      r_sync_byte      <= i_cfg_data;
                fpp_pkg::CFG_OVERHEAD_BYTES: r_overhead_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.sync_byte      = r_sync_byte;
    assign o_cfg.overhead_bytes = r_overhead_bytes;

endmodule

[hdl/fpp_parse.sv]
// frame parser state machine, fletcher sums and saturating error counter
// depends on fpp_pkg and assert_macros.svh
`include "assert_macros.svh"

module fpp_parse #(
    parameter int ERROR_COUNT_WIDTH = fpp_pkg::ERROR_COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    input  fpp_pkg::t_cfg    i_cfg,
    output fpp_pkg::t_result o_result
);

    fpp_pkg::t_phase              r_phase, n_phase;
    logic [7:0]                   r_sum_first, n_sum_first;
    logic [7:0]                   r_sum_second, n_sum_second;
    logic [7:0]                   r_frame_length, n_frame_length;
    logic [7:0]                   r_byte_index, n_byte_index;
    logic [7:0]                   r_aircraft_id, n_aircraft_id;
    logic [7:0]                   r_message_id, n_message_id;
    logic [ERROR_COUNT_WIDTH-1:0] r_errors, n_errors;

    logic [7:0]                   w_acc_first;
    logic [7:0]                   w_acc_second;
    logic [7:0]                   w_index_inc;
    logic [ERROR_COUNT_WIDTH-1:0] w_errors_inc;
    logic [ERROR_COUNT_WIDTH+15:0] w_errors_ext;
    logic [1:0]                   w_event;
    logic [7:0]                   w_payload_byte;
    logic [7:0]                   w_payload_index;

    assign w_acc_first  = r_sum_first + i_rx_byte;
    assign w_acc_second = r_sum_second + w_acc_first;
    assign w_index_inc  = r_byte_index + 8'd1;
    // counter holds once all ones
    assign w_errors_inc = (&r_errors) ? r_errors : r_errors + 1'b1;

    always_comb begin
        n_phase         = r_phase;
        n_sum_first     = r_sum_first;
        n_sum_second    = r_sum_second;
        n_frame_length  = r_frame_length;
        n_byte_index    = r_byte_index;
        n_aircraft_id   = r_aircraft_id;
        n_message_id    = r_message_id;
        n_errors        = r_errors;
        w_event         = fpp_pkg::EV_NONE;
        w_payload_byte  = 8'd0;
        w_payload_index = 8'd0;
        unique case (r_phase)
            fpp_pkg::PH_LEN: begin
                n_frame_length = i_rx_byte - i_cfg.overhead_bytes;
                n_byte_index   = 8'd0;
                n_sum_first    = w_acc_first;
                n_sum_second   = w_acc_second;
                n_phase        = fpp_pkg::PH_ACID;
            end
            fpp_pkg::PH_ACID: begin
                n_aircraft_id = i_rx_byte;
                n_sum_first   = w_acc_first;
                n_sum_second  = w_acc_second;
                n_phase       = fpp_pkg::PH_MSGID;
            end
            fpp_pkg::PH_MSGID: begin
                n_message_id = i_rx_byte;
                n_sum_first  = w_acc_first;
                n_sum_second = w_acc_second;
                // empty payload skips straight to the checksum
                n_phase      = (r_frame_length == 8'd0) ? fpp_pkg::PH_CK1
                                                        : fpp_pkg::PH_PAYLOAD;
            end
            fpp_pkg::PH_PAYLOAD: begin
                w_event         = fpp_pkg::EV_BYTE;
                w_payload_byte  = i_rx_byte;
                w_payload_index = r_byte_index;
                n_byte_index    = w_index_inc;
                n_sum_first     = w_acc_first;
                n_sum_second    = w_acc_second;
                if (w_index_inc == r_frame_length) begin
                    n_phase = fpp_pkg::PH_CK1;
                end
            end
            fpp_pkg::PH_CK1: begin
                if (i_rx_byte != r_sum_first) begin
                    w_event  = fpp_pkg::EV_ERROR;
                    n_errors = w_errors_inc;
                    n_phase  = fpp_pkg::PH_HUNT;
                end else begin
                    n_phase = fpp_pkg::PH_CK2;
                end
            end
            fpp_pkg::PH_CK2: begin
                if (i_rx_byte != r_sum_second) begin
                    w_event  = fpp_pkg::EV_ERROR;
                    n_errors = w_errors_inc;
                end else begin
                    w_event = fpp_pkg::EV_GOOD;
                end
                n_phase = fpp_pkg::PH_HUNT;
            end
            default: begin
                // hunting: sync byte seeds both sums
                if (i_rx_byte == i_cfg.sync_byte) begin
                    n_sum_first  = i_cfg.sync_byte;
                    n_sum_second = i_cfg.sync_byte;
                    n_phase      = fpp_pkg::PH_LEN;
                end else begin
                    n_phase = fpp_pkg::PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= fpp_pkg::PH_HUNT;
            r_sum_first    <= 8'd0;
            r_sum_second   <= 8'd0;
            r_frame_length <= 8'd0;
            r_byte_index   <= 8'd0;
            r_aircraft_id  <= 8'd0;
            r_message_id   <= 8'd0;
            r_errors       <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_sum_first    <= n_sum_first;
            r_sum_second   <= n_sum_second;
            r_frame_length <= n_frame_length;
            r_byte_index   <= n_byte_index;
            r_aircraft_id  <= n_aircraft_id;
            r_message_id   <= n_message_id;
            r_errors       <= n_errors;
        end
    end

    // reported count is the low 16 bits, zero filled for narrow counters
    assign w_errors_ext = {16'd0, n_errors};

    assign o_result.event_res      = w_event;
    assign o_result.payload_byte   = w_payload_byte;
    assign o_result.payload_index  = w_payload_index;
    assign o_result.payload_length = n_frame_length;
    assign o_result.aircraft_id    = n_aircraft_id;
    assign o_result.message_id     = n_message_id;
    assign o_result.error_count    = w_errors_ext[15:0];

    `FPP_ASSERT_SAME(a_index_below_length, i_clk, i_rst_n,
        r_phase == fpp_pkg::PH_PAYLOAD, r_byte_index != r_frame_length,
        "payload phase with index at frame length")
    `FPP_ASSERT_NEXT(a_errors_only_on_error, i_clk, i_rst_n,
        !i_accept || w_event != fpp_pkg::EV_ERROR, r_errors == $past(r_errors),
        "error counter moved without an error beat")
    `FPP_ASSERT_NEXT(a_sums_seeded, i_clk, i_rst_n,
        i_accept && r_phase == fpp_pkg::PH_HUNT && n_phase == fpp_pkg::PH_LEN,
        r_sum_first == r_sum_second,
        "checksum sums not seeded alike after sync")

endmodule

[hdl/fpp_out.sv]
// result register with valid/ready toward the receiver
// depends on fpp_pkg and assert_macros.svh
`include "assert_macros.svh"

module fpp_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  fpp_pkg::t_result i_result,
    input  logic             i_out_ready,
    output logic             o_can_load,
    output logic             o_out_valid,
    output fpp_pkg::t_result o_result
);

    logic             r_valid, n_valid;
    fpp_pkg::t_result r_result;

    // a new beat may enter while the held one leaves
    assign o_can_load = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    `FPP_ASSERT_NEXT(a_load_gives_valid, i_clk, i_rst_n,
        i_load, r_valid,
        "loaded beat not presented")
    `FPP_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n,
        i_load, !r_valid || i_out_ready,
        "held result overwritten before it was taken")

endmodule

[hdl/framed_packet_parser_top.sv]
// framed packet parser: sync hunt, length/id header, streamed payload,
// fletcher-16 style checksum check with a saturating error counter.
//
// input channel: one received byte per beat on i_rx_byte (i_in_valid/o_in_ready).
// output channel: exactly one result beat per input beat (o_out_valid/
// i_out_ready) with the event code, the payload byte and its index on a
// payload event, and the held length, ids and error count after that byte.
// config channel: i_cfg_index 0 writes the sync byte, 1 the overhead byte
// count, other indexes are ignored; o_cfg_ready is always high.
// latency: the result of a byte is presented the cycle after it is accepted.
// throughput: one byte per cycle while results are taken; the parser state and
// the result register both update at the accepting edge.
// stall: while a result waits unread o_in_ready falls, and rises again in
// the cycle the result is taken, so no beat is lost or repeated.
// reset (synchronous, active low): parser goes back to hunting, sums,
// header fields and error count clear, sync byte 153, overhead 6, no result.
// depends on fpp_pkg, fpp_cfg, fpp_parse, fpp_out
module framed_packet_parser_top #(
    parameter int ERROR_COUNT_WIDTH = fpp_pkg::ERROR_COUNT_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_rx_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_event_res,
    output logic [7:0]                         o_payload_byte,
    output logic [7:0]                         o_payload_index,
    output logic [7:0]                         o_payload_length,
    output logic [7:0]                         o_aircraft_id,
    output logic [7:0]                         o_message_id,
    output logic [15:0]                        o_error_count,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fpp_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [7:0]                         i_cfg_data
);

    fpp_pkg::t_cfg    w_cfg;
    fpp_pkg::t_result w_next_result;
    fpp_pkg::t_result w_out_result;
    logic             w_can_load;
    logic             w_accept;

    assign o_in_ready = w_can_load;
    assign w_accept   = i_in_valid && w_can_load;

    fpp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    fpp_parse #(
        .ERROR_COUNT_WIDTH (ERROR_COUNT_WIDTH)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (w_cfg),
        .o_result  (w_next_result)
    );

    fpp_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_result    (w_next_result),
        .i_out_ready (i_out_ready),
        .o_can_load  (w_can_load),
        .o_out_valid (o_out_valid),
        .o_result    (w_out_result)
    );

    assign o_event_res      = w_out_result.event_res;
    assign o_payload_byte   = w_out_result.payload_byte;
    assign o_payload_index  = w_out_result.payload_index;
    assign o_payload_length = w_out_result.payload_length;
    assign o_aircraft_id    = w_out_result.aircraft_id;
    assign o_message_id     = w_out_result.message_id;
    assign o_error_count    = w_out_result.error_count;

endmodule
